// ===== hdl/fvt_pkg.sv =====
// Package for the frustum visibility test: field widths, register
// indexes and the plane unpack helpers. No dependencies.
package fvt_pkg;

	localparam int NUM_PLANES_DEF = 6;
	localparam int REG_COUNT      = 6;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 64;

	localparam int COORD_W = 24;
	localparam int RAD_W   = 23;
	localparam int NRM_W   = 13;
	localparam int W_W     = 25;
	localparam int FRAC_W  = 12;
	localparam int CEN_W   = COORD_W + 1;
	localparam int EXT_W   = COORD_W;
	localparam int PC_W    = NRM_W + CEN_W;
	localparam int PE_W    = NRM_W + EXT_W;
	localparam int ACC_W   = PC_W + 6;

	localparam int NX_LSB = 0;
	localparam int NY_LSB = NRM_W;
	localparam int NZ_LSB = 2 * NRM_W;
	localparam int W_LSB  = 3 * NRM_W;

	localparam logic [CFG_IDX_W-1:0] REG_PLANE_LEFT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PLANE_RIGHT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PLANE_BOTTOM = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PLANE_TOP    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PLANE_NEAR   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PLANE_FAR    = 3'd5;

	localparam logic signed [NRM_W-1:0] NRM_MOST_NEG = {1'b1, {(NRM_W-1){1'b0}}};

	typedef logic signed [CEN_W-1:0] cen_t;
	typedef logic signed [EXT_W-1:0] ext_t;
	typedef logic signed [NRM_W-1:0] nrm_t;

	typedef struct packed {
		logic en2;
		logic en3;
		logic en4;
	} stage_en_t;

	// -4096 clamps to -4095
	function automatic nrm_t sat_normal(input logic [NRM_W-1:0] raw);
		nrm_t n;
		n = signed'(raw);
		if (n == NRM_MOST_NEG) begin
			n = NRM_MOST_NEG + nrm_t'(1);
		end
		return n;
	endfunction

	function automatic nrm_t abs_normal(input nrm_t n);
		nrm_t a;
		a = n[NRM_W-1] ? -n : n;
		return a;
	endfunction

endpackage

// ===== hdl/fvt_plane_lane.sv =====
// One plane lane: products, partial sums and the cull decision for one plane.
// Depends on fvt_pkg.
module fvt_plane_lane
	import fvt_pkg::*;
(
	input  logic                  clk,
	input  logic [CFG_DATA_W-1:0] plane,
	input  stage_en_t             en,
	input  cen_t                  c_s1 [3],
	input  ext_t                  e_s1 [3],
	input  logic                  op_s2,
	input  logic [RAD_W-1:0]      rad_s2,
	output logic                  cull_s4
);

	nrm_t n [3];
	nrm_t na [3];
	logic signed [W_W-1:0] w;

	logic signed [PC_W-1:0] pc_s2 [3];
	logic signed [PE_W-1:0] pe_s2 [3];
	logic signed [W_W-1:0]  w_s2;
	logic signed [ACC_W-1:0] dp_s3;
	logic signed [ACC_W-1:0] rp_s3;

	logic signed [ACC_W-1:0] dp_c;
	logic signed [ACC_W-1:0] rbox_c;
	logic signed [ACC_W-1:0] rsph_c;
	logic signed [ACC_W-1:0] tot_c;

	always_comb begin
		n[0] = sat_normal(plane[NX_LSB +: NRM_W]);
		n[1] = sat_normal(plane[NY_LSB +: NRM_W]);
		n[2] = sat_normal(plane[NZ_LSB +: NRM_W]);
		w    = signed'(plane[W_LSB +: W_W]);
		for (int k = 0; k < 3; k++) begin
			na[k] = abs_normal(n[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (en.en2) begin
			for (int k = 0; k < 3; k++) begin
				pc_s2[k] <= PC_W'(n[k]) * PC_W'(c_s1[k]);
				pe_s2[k] <= PE_W'(na[k]) * PE_W'(e_s1[k]);
			end
			w_s2 <= w;
		end
	end

	always_comb begin
		dp_c = ACC_W'(pc_s2[0]) + ACC_W'(pc_s2[1]) + ACC_W'(pc_s2[2])
			+ ACC_W'($signed({w_s2, {FRAC_W{1'b0}}}));
		rbox_c = ACC_W'(pe_s2[0]) + ACC_W'(pe_s2[1]) + ACC_W'(pe_s2[2]);
		rsph_c = ACC_W'($signed({1'b0, rad_s2, {FRAC_W{1'b0}}}));
	end

	always_ff @(posedge clk) begin
		if (en.en3) begin
			dp_s3 <= dp_c;
			rp_s3 <= op_s2 ? rsph_c : rbox_c;
		end
	end

	assign tot_c = dp_s3 + rp_s3;

	always_ff @(posedge clk) begin
		if (en.en4) begin
			cull_s4 <= tot_c[ACC_W-1];
		end
	end

endmodule

// ===== hdl/frustum_visibility_test.sv =====
// Frustum visibility test top level: plane registers, input stage and valid
// pipeline around one fvt_plane_lane per tested plane. Depends on fvt_pkg.
//
// Tests a box or a sphere against the first NUM_PLANES of six plane
// registers and returns visible = 1 when no plane has the volume wholly on
// its negative side. One beat is accepted every cycle while in_stall is low;
// the result passes through the input stage and the three register stages
// of the plane lanes (extent/center add, multipliers, partial sums, final
// add and sign), which all run in parallel. Empty stages close up under
// out_stall, so input is still taken while a result waits. The user must
// write planes through cfg_wr/cfg_index/cfg_data only while no beat is in
// flight; the block does not enforce this. Indexes above five are ignored,
// and lanes beyond the sixth register never cull.
module frustum_visibility_test
	import fvt_pkg::*;
#(
	parameter int NUM_PLANES = NUM_PLANES_DEF
)
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  operation,
	input  logic [COORD_W-1:0]    box_min_x,
	input  logic [COORD_W-1:0]    box_min_y,
	input  logic [COORD_W-1:0]    box_min_z,
	input  logic [COORD_W-1:0]    box_max_x,
	input  logic [COORD_W-1:0]    box_max_y,
	input  logic [COORD_W-1:0]    box_max_z,
	input  logic [COORD_W-1:0]    sphere_center_x,
	input  logic [COORD_W-1:0]    sphere_center_y,
	input  logic [COORD_W-1:0]    sphere_center_z,
	input  logic [RAD_W-1:0]      sphere_radius,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  visible
);

	logic [CFG_DATA_W-1:0] plane_q [REG_COUNT];

	logic v_s1, v_s2, v_s3, v_s4;
	logic adv1, adv2, adv3, adv4;
	stage_en_t en;

	logic             op_s1, op_s2;
	logic [RAD_W-1:0] rad_s1, rad_s2;
	cen_t             c_s1 [3];
	ext_t             e_s1 [3];

	logic signed [COORD_W-1:0] lo [3];
	logic signed [COORD_W-1:0] hi [3];
	logic signed [COORD_W-1:0] sc [3];
	logic signed [CEN_W-1:0]   diff [3];
	ext_t                      ext_c [3];
	cen_t                      cen_c [3];

	logic [NUM_PLANES-1:0] cull_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < REG_COUNT; i++) begin
				plane_q[i] <= '0;
			end
		end else if (cfg_wr) begin
			case (cfg_index)
				REG_PLANE_LEFT:   plane_q[0] <= cfg_data;
				REG_PLANE_RIGHT:  plane_q[1] <= cfg_data;
				REG_PLANE_BOTTOM: plane_q[2] <= cfg_data;
				REG_PLANE_TOP:    plane_q[3] <= cfg_data;
				REG_PLANE_NEAR:   plane_q[4] <= cfg_data;
				REG_PLANE_FAR:    plane_q[5] <= cfg_data;
				default: ;
			endcase
		end
	end

	assign adv4 = !v_s4 || !out_stall;
	assign adv3 = !v_s3 || adv4;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;
	assign in_stall = !adv1;
	assign en = '{en2: adv2, en3: adv3, en4: adv4};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv4) v_s4 <= v_s3;
		end
	end

	always_comb begin
		lo[0] = signed'(box_min_x);
		lo[1] = signed'(box_min_y);
		lo[2] = signed'(box_min_z);
		hi[0] = signed'(box_max_x);
		hi[1] = signed'(box_max_y);
		hi[2] = signed'(box_max_z);
		sc[0] = signed'(sphere_center_x);
		sc[1] = signed'(sphere_center_y);
		sc[2] = signed'(sphere_center_z);
		for (int k = 0; k < 3; k++) begin
			diff[k]  = CEN_W'(hi[k]) - CEN_W'(lo[k]);
			ext_c[k] = diff[k][CEN_W-1:1];
			cen_c[k] = CEN_W'(lo[k]) + CEN_W'(ext_c[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			op_s1  <= operation;
			rad_s1 <= sphere_radius;
			for (int k = 0; k < 3; k++) begin
				c_s1[k] <= operation ? CEN_W'(sc[k]) : cen_c[k];
				e_s1[k] <= operation ? '0 : ext_c[k];
			end
		end
		if (adv2) begin
			op_s2  <= op_s1;
			rad_s2 <= rad_s1;
		end
	end

	for (genvar i = 0; i < NUM_PLANES; i++) begin : g_lane
		logic [CFG_DATA_W-1:0] plane_sel;
		if (i < REG_COUNT) begin : g_reg
			assign plane_sel = plane_q[i];
		end else begin : g_zero
			assign plane_sel = '0;
		end
		fvt_plane_lane u_lane (
			.clk     (clk),
			.plane   (plane_sel),
			.en      (en),
			.c_s1    (c_s1),
			.e_s1    (e_s1),
			.op_s2   (op_s2),
			.rad_s2  (rad_s2),
			.cull_s4 (cull_s4[i])
		);
	end

	assign out_valid = v_s4;
	assign visible   = ~|cull_s4;

endmodule
